/* design/htfl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htfl_pkg: shared types and constants of the hex text flash loader
// Holds the character codes, result kinds, register indexes, reset values
// and the digit decoder used by the loader modules.
// ----------------------------------------------------------------------------
package htfl_pkg;

	// Configuration channel widths
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_A_START = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_END   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_START = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_END   = 8'd3;

	// Register reset values
	localparam logic [15:0] RST_A_START = 16'h5C00;
	localparam logic [15:0] RST_A_END   = 16'hF000;
	localparam logic [15:0] RST_B_START = 16'hFD00;
	localparam logic [15:0] RST_B_END   = 16'hFFFE;

	// Write pointer value after reset
	localparam logic [15:0] RST_WPTR = 16'h5C00;

	// Special characters
	localparam logic [7:0] CHAR_AT = 8'h40;
	localparam logic [7:0] CHAR_Q  = 8'h71;

	// Result kinds
	localparam logic [1:0] KIND_ADDR  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_DROP  = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// Writable regions as held by the register block
	typedef struct packed {
		logic [15:0] a_start;
		logic [15:0] a_end;
		logic [15:0] b_start;
		logic [15:0] b_end;
	} region_cfg_t;

	// One result transaction
	typedef struct packed {
		logic [1:0]  word_kind;
		logic [15:0] target_address;
		logic [15:0] write_word;
		logic        image_done;
	} result_t;

	// Digit decode: bit 4 set when the character is an uppercase hex digit.
	function automatic logic [4:0] decode_digit(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'd48;
			return {1'b1, v[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'd55;
			return {1'b1, v[3:0]};
		end
		return 5'd0;
	endfunction

endpackage
`default_nettype wire

/* design/htfl_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htfl_if: channel interfaces of the hex text flash loader
// Character input, result output and configuration write channels, each
// with valid, ready and its payload.
// ----------------------------------------------------------------------------

// Character channel
interface htfl_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;

	modport source (output valid, output text_char, input ready);
	modport sink   (input valid, input text_char, output ready);
endinterface

// Result channel
interface htfl_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  word_kind;
	logic [15:0] target_address;
	logic [15:0] write_word;
	logic        image_done;

	modport source (output valid, output word_kind, output target_address,
		output write_word, output image_done, input ready);
	modport sink   (input valid, input word_kind, input target_address,
		input write_word, input image_done, output ready);
endinterface

// Configuration write channel
interface htfl_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/hex_text_flash_loader_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hex_text_flash_loader_top: hex text image to flash write converter
// Parses a stream of ASCII characters into address loads and byte-swapped
// flash word writes, guarded by two configurable writable regions.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                            Role
//  chars     in   text_char[7:0]                                     image text
//  results   out  word_kind[1:0] target_address[15:0]
//                 write_word[15:0] image_done                        word results
//  cfg       in   index[7:0] data[15:0]                              region registers
//
//  One character is taken every cycle unless the result register stalls; a result
//  passes through the input register and then the result register after its
//  character is accepted, and is presented from the result register.
//  The configuration channel is always ready and takes effect on the next cycle.
//  A stalled result register holds the character stage only when that stage
//  would produce a result; the input is still taken whenever the stage is free.
//  Reset clears the digit slots and address mode and loads the default regions.
// ----------------------------------------------------------------------------
module hex_text_flash_loader_top
	import htfl_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	htfl_char_if.sink        chars,
	htfl_res_if.source       results,
	htfl_cfg_if.sink         cfg
);

	region_cfg_t regions;

	// Region registers
	htfl_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.regions (regions)
	);

	// Character parser and result register
	htfl_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.regions (regions),
		.chars   (chars),
		.results (results)
	);

endmodule
`default_nettype wire

/* design/htfl_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htfl_cfg_regs: region configuration registers
// Holds the bounds of the two writable regions. Writes to an index beyond
// the register list are accepted and have no effect.
// ----------------------------------------------------------------------------
module htfl_cfg_regs
	import htfl_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	htfl_cfg_if.sink         cfg,
	output region_cfg_t      regions
);

	region_cfg_t regions_q;
	logic        wr_en;

	// The register file never stalls a write.
	assign cfg.ready = 1'b1;
	assign wr_en     = cfg.valid && cfg.ready;
	assign regions   = regions_q;

	// Register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regions_q.a_start <= RST_A_START;
			regions_q.a_end   <= RST_A_END;
			regions_q.b_start <= RST_B_START;
			regions_q.b_end   <= RST_B_END;
		end else if (wr_en) begin
			unique case (cfg.index)
				REG_A_START: regions_q.a_start <= cfg.data;
				REG_A_END:   regions_q.a_end   <= cfg.data;
				REG_B_START: regions_q.b_start <= cfg.data;
				REG_B_END:   regions_q.b_end   <= cfg.data;
				default: ;
			endcase
		end
	end

	// A write to the lower region start lands in that register.
	a_start_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && cfg.index == REG_A_START |=> regions_q.a_start == $past(cfg.data))
		else $error("region_a_start not updated by its write");

	// A write to the upper region end lands in that register.
	b_end_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && cfg.index == REG_B_END |=> regions_q.b_end == $past(cfg.data))
		else $error("region_b_end not updated by its write");

	// A write beyond the register list changes nothing.
	stray_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && cfg.index != REG_A_START && cfg.index != REG_A_END &&
		cfg.index != REG_B_START && cfg.index != REG_B_END |=> $stable(regions_q))
		else $error("write beyond the register list changed a region");

endmodule
`default_nettype wire

/* design/htfl_parse.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// htfl_parse: character parser and flash write generator
// Registers each character, decodes it against the digit slots, the write
// pointer and the address mode, and places any result in an output register.
// ----------------------------------------------------------------------------
module htfl_parse
	import htfl_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire region_cfg_t regions,
	htfl_char_if.sink        chars,
	htfl_res_if.source       results
);

	// Input register
	logic        valid_s1;
	logic [7:0]  char_s1;

	// Parser state
	logic [4:0]  slots_q [4];
	logic [1:0]  pos_q;
	logic [15:0] wptr_q;
	logic        expect_q;

	// Output register
	logic        out_valid_q;
	result_t     out_q;

	// Decode and next-state signals
	logic        is_at, is_q, is_digit;
	logic [4:0]  dig;
	logic        produces, advance;
	logic [4:0]  slots_nx [4];
	logic [15:0] word;
	logic [15:0] swapped;
	logic        writable;
	result_t     res;

	// Character classes
	assign dig      = decode_digit(char_s1);
	assign is_digit = dig[4];
	assign is_at    = (char_s1 == CHAR_AT);
	assign is_q     = (char_s1 == CHAR_Q);
	assign produces = is_q || (is_digit && pos_q == 2'd3);

	// The stage moves on unless its result would land on a full output register.
	assign advance     = valid_s1 && (!produces || !out_valid_q || results.ready);
	assign chars.ready = !valid_s1 || advance;

	// Slot contents after this character and the word they form
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			slots_nx[i] = slots_q[i];
		end
		if (is_digit) begin
			slots_nx[pos_q] = dig;
		end
		word = 16'd0;
		for (int i = 0; i < 4; i++) begin
			if (slots_nx[i][4]) begin
				word = {word[11:0], slots_nx[i][3:0]};
			end
		end
	end

	assign swapped  = {word[7:0], word[15:8]};
	assign writable = ((wptr_q >= regions.a_start && wptr_q < regions.a_end) ||
		(wptr_q >= regions.b_start && wptr_q < regions.b_end)) &&
		(wptr_q != regions.b_end);

	// Result of this character
	always_comb begin
		res.image_done = is_q;
		if (is_q && pos_q == 2'd0) begin
			res.word_kind      = KIND_NONE;
			res.target_address = 16'd0;
			res.write_word     = 16'd0;
		end else if (!expect_q) begin
			res.word_kind      = KIND_ADDR;
			res.target_address = word;
			res.write_word     = 16'd0;
		end else begin
			res.word_kind      = writable ? KIND_WRITE : KIND_DROP;
			res.target_address = wptr_q;
			res.write_word     = swapped;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.text_char;
		end
	end

	// Parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				slots_q[i] <= 5'd0;
			end
			pos_q    <= 2'd0;
			wptr_q   <= RST_WPTR;
			expect_q <= 1'b0;
		end else if (advance) begin
			if (is_at) begin
				expect_q <= 1'b0;
			end
			if (is_digit) begin
				slots_q[pos_q] <= dig;
				pos_q          <= pos_q + 2'd1;
			end
			if (produces && !(is_q && pos_q == 2'd0)) begin
				if (!expect_q) begin
					wptr_q   <= word;
					expect_q <= 1'b1;
				end else if (writable) begin
					wptr_q <= wptr_q + 16'd2;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produces) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produces) begin
			out_q <= res;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.word_kind      = out_q.word_kind;
	assign results.target_address = out_q.target_address;
	assign results.write_word     = out_q.write_word;
	assign results.image_done     = out_q.image_done;

	// A granted write steps the pointer by one word.
	ptr_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && produces && res.word_kind == KIND_WRITE
		|=> wptr_q == $past(wptr_q) + 16'd2)
		else $error("write pointer did not step after a write");

	// A dropped write leaves the pointer alone.
	ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && produces && res.word_kind == KIND_DROP |=> $stable(wptr_q))
		else $error("write pointer moved on a dropped write");

	// A result never overwrites one that has not been taken.
	no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		advance && produces |-> !out_valid_q || results.ready)
		else $error("result register overrun");

	// Input back-pressure only comes from a stalled output register.
	stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> valid_s1 && out_valid_q && !results.ready)
		else $error("input stalled without an output stall");

endmodule
`default_nettype wire
